// ===== rtl/fully_associative_cache_random_replace_defines.svh =====
// Assertion macros shared by the cache checker.
`ifndef FULLY_ASSOCIATIVE_CACHE_RANDOM_REPLACE_DEFINES_SVH
`define FULLY_ASSOCIATIVE_CACHE_RANDOM_REPLACE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FACR_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cache port check failed");

// Check a property on every clock edge, reset included.
`define FACR_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cache reset check failed");

`endif

// ===== rtl/facr_pkg.sv =====
// Package: constants, types and controller encoding of the cache tag store.
`timescale 1ns / 1ps
package facr_pkg;

  localparam int LINE_BYTES    = 32;
  localparam int MAX_LINES     = 512;
  localparam int ADDRESS_BITS  = 26;

  localparam int BYTE_SEL_BITS = $clog2(LINE_BYTES);
  localparam int TAG_BITS      = ADDRESS_BITS - BYTE_SEL_BITS;
  localparam int LINE_IDX_BITS = $clog2(MAX_LINES);
  localparam int COUNT_BITS    = LINE_IDX_BITS + 1;
  localparam int CFG_BITS      = 10;
  localparam int LINES_RESET   = 512;

  // Tag memory rows: several tags per row, compared side by side.
  localparam int LANES         = 16;
  localparam int LANE_BITS     = $clog2(LANES);
  localparam int ROWS          = MAX_LINES / LANES;
  localparam int ROW_BITS      = $clog2(ROWS);
  localparam int ROW_CNT_BITS  = $clog2(ROWS + 1);

  localparam int WORD_BITS     = 32;
  localparam int DIV_CNT_BITS  = $clog2(WORD_BITS + 1);

  localparam int IN_DATA_BITS  = ((ADDRESS_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = LINE_IDX_BITS + WORD_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 2;

  localparam logic [WORD_BITS-1:0] RNG_UPPER_RESET = 32'h0508_0902;
  localparam logic [WORD_BITS-1:0] RNG_LOWER_RESET = 32'hABAB_AB55;
  localparam logic [WORD_BITS-1:0] RNG_UPPER_MUL   = 32'd36969;
  localparam logic [WORD_BITS-1:0] RNG_LOWER_MUL   = 32'd18000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RNG,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic take_hit;
    logic take_fill;
    logic rng_step;
    logic div_start;
    logic div_step;
    logic take_evict;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_end;
    logic full;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/fully_associative_cache_random_replace.sv =====
// Top level: fully associative cache tag store with random replacement.
//
// Usage:
//   s_axis carries one read byte address per transfer in s_axis_tdata. Each
//   accepted address yields exactly one result transfer on m_axis: the line
//   that hit, was filled, or was replaced, plus the saturating hit total.
//   cfg carries the lines-in-use register (1..512; 0 acts as 1, larger
//   values act as 512); write it only while no lookup is in flight.
// Timing:
//   The tags sit in a memory of 32 rows of 16 tags; the lookup reads one row
//   per cycle and compares its 16 tags at once, stopping at the first hit.
//   A lookup reads only the filled rows; after it, the result is loaded
//   into the output register. A miss with every line in use first draws a
//   random word and then reduces it to a line by a bit-serial remainder.
//   One address is in work at a time; s_axis_tready is high only when idle.
// Reset:
//   rst clears the fill count, hit total and handshakes, loads the generator
//   seeds and sets lines in use to 512; the tag memory needs no clearing pass.
// Stalls:
//   A result waits in the output register while m_axis_tready is low; the
//   next address is still accepted and looked up meanwhile, and its result
//   is held back until the register frees.
`timescale 1ns / 1ps
module fully_associative_cache_random_replace (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // fields from bit 0: address
  input  logic [facr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fields from bit 0: line_index, hit_total
  output logic [facr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // fields from bit 0: hit, evicted
  output logic [facr_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [facr_pkg::CFG_BITS-1:0]       cfg_data
);
  import facr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The register takes a write on any cycle.
  assign cfg_ready = 1'b1;

  facr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  facr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

// ===== rtl/facr_ctrl.sv =====
// Controller: sequences lookup, fill, random replacement and result hand-off.
`timescale 1ns / 1ps
module facr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  facr_pkg::status_t status,
  output facr_pkg::cmd_t    cmd
);
  import facr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_hit) begin
          state_next = ST_DONE;
        end else if (status.scan_end) begin
          state_next = status.full ? ST_RNG : ST_DONE;
        end
      end
      ST_RNG:      state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.take_hit  = status.scan_hit;
        cmd.take_fill = !status.scan_hit && status.scan_end && !status.full;
      end
      ST_RNG:      cmd.rng_step  = 1'b1;
      ST_DIV_LOAD: cmd.div_start = 1'b1;
      ST_DIV: begin
        cmd.div_step   = !status.div_done;
        cmd.take_evict = status.div_done;
      end
      ST_DONE:     cmd.out_load = status.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

// ===== rtl/facr_datapath.sv =====
// Datapath: tag memory, fill count, random generator, divider, result register.
`timescale 1ns / 1ps
module facr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [facr_pkg::IN_DATA_BITS-1:0]   in_data,
  input  logic                                cfg_write,
  input  logic [facr_pkg::CFG_BITS-1:0]       cfg_value,
  input  facr_pkg::cmd_t                      cmd,
  output facr_pkg::status_t                   status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [facr_pkg::OUT_DATA_BITS-1:0]  out_data,
  output logic [facr_pkg::OUT_USER_BITS-1:0]  out_user
);
  import facr_pkg::*;

  logic [CFG_BITS-1:0]      lines_in_use;
  logic [COUNT_BITS-1:0]    n_eff;
  logic [COUNT_BITS-1:0]    fill_count;
  logic [TAG_BITS-1:0]      tag;

  logic [LANES-1:0][TAG_BITS-1:0] tag_mem [ROWS];
  logic [LANES-1:0][TAG_BITS-1:0] row_data;

  logic [ROW_CNT_BITS-1:0]  rd_row;
  logic [ROW_BITS-1:0]      cmp_row;
  logic                     rd_pend;
  logic [COUNT_BITS:0]      rows_sum;
  logic [ROW_CNT_BITS-1:0]  rows_used;
  logic                     rd_issue;
  logic [LANES-1:0]         lane_match;
  logic [LANE_BITS-1:0]     hit_lane;

  logic [WORD_BITS-1:0]     rng_upper, rng_lower, hit_count;
  logic [WORD_BITS-1:0]     rng_upper_next, rng_lower_next;
  logic [WORD_BITS-1:0]     dividend;
  logic [LINE_IDX_BITS-1:0] rem;
  logic [COUNT_BITS-1:0]    trial;
  logic [DIV_CNT_BITS-1:0]  div_cnt;

  logic                     res_hit, res_evicted;
  logic [LINE_IDX_BITS-1:0] res_pos;
  logic                     mem_we;
  logic [LINE_IDX_BITS-1:0] wr_line;

  // Clamp the register to the range of lines that exist.
  always_comb begin
    if (lines_in_use == '0) begin
      n_eff = COUNT_BITS'(1);
    end else if (int'(lines_in_use) > MAX_LINES) begin
      n_eff = COUNT_BITS'(MAX_LINES);
    end else begin
      n_eff = COUNT_BITS'(lines_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_in_use <= CFG_BITS'(LINES_RESET);
    end else if (cfg_write) begin
      lines_in_use <= cfg_value;
    end
  end

  // Lines fill in ascending order and are never dropped, so the valid lines
  // are always lines 0 .. fill_count-1.
  assign rows_sum  = {1'b0, fill_count} + (COUNT_BITS + 1)'(LANES - 1);
  assign rows_used = rows_sum[LANE_BITS +: ROW_CNT_BITS];
  assign rd_issue  = cmd.scan && (rd_row < rows_used);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_match[l] = (row_data[l] == tag) &&
                      (COUNT_BITS'({cmp_row, LANE_BITS'(l)}) < fill_count);
    end
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane_match[l]) hit_lane = LANE_BITS'(l);
    end
  end

  assign status.scan_hit = rd_pend && (|lane_match);
  assign status.scan_end = !rd_pend && (rd_row >= rows_used);
  assign status.full     = fill_count >= n_eff;
  assign status.div_done = div_cnt == DIV_CNT_BITS'(WORD_BITS);
  assign status.out_free = !out_valid || out_ready;

  // Tag memory: one read row and one written tag per cycle.
  assign mem_we  = cmd.take_fill || cmd.take_evict;
  assign wr_line = cmd.take_fill ? fill_count[LINE_IDX_BITS-1:0] : rem;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wr_line[LINE_IDX_BITS-1:LANE_BITS]][wr_line[LANE_BITS-1:0]] <= tag;
    end
    if (rd_issue) begin
      row_data <= tag_mem[rd_row[ROW_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag <= in_data[ADDRESS_BITS-1:BYTE_SEL_BITS];
    end
    if (rd_issue) begin
      cmp_row <= rd_row[ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_row  <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.start) begin
      rd_row  <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.scan) begin
      rd_pend <= rd_issue;
      if (rd_issue) rd_row <= rd_row + ROW_CNT_BITS'(1);
    end
  end

  // Multiply-with-carry generator, advanced once per replacement.
  always_comb begin
    rng_upper_next = RNG_UPPER_MUL * {16'd0, rng_upper[15:0]} + {16'd0, rng_upper[31:16]};
    rng_lower_next = RNG_LOWER_MUL * {16'd0, rng_lower[15:0]} + {16'd0, rng_lower[31:16]};
  end

  // Restoring remainder, one dividend bit per step.
  assign trial = {rem, dividend[WORD_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend <= {rng_upper[15:0], 16'd0} + rng_lower;
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[WORD_BITS-2:0], 1'b0};
      if (trial >= n_eff) begin
        rem <= LINE_IDX_BITS'(trial - n_eff);
      end else begin
        rem <= trial[LINE_IDX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      hit_count  <= '0;
      rng_upper  <= RNG_UPPER_RESET;
      rng_lower  <= RNG_LOWER_RESET;
      div_cnt    <= '0;
    end else begin
      if (cmd.take_fill) fill_count <= fill_count + COUNT_BITS'(1);
      if (cmd.take_hit && hit_count != '1) hit_count <= hit_count + WORD_BITS'(1);
      if (cmd.rng_step) begin
        rng_upper <= rng_upper_next;
        rng_lower <= rng_lower_next;
      end
      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_hit     <= 1'b1;
      res_evicted <= 1'b0;
      res_pos     <= {cmp_row, hit_lane};
    end else if (cmd.take_fill) begin
      res_hit     <= 1'b0;
      res_evicted <= 1'b0;
      res_pos     <= fill_count[LINE_IDX_BITS-1:0];
    end else if (cmd.take_evict) begin
      res_hit     <= 1'b0;
      res_evicted <= 1'b1;
      res_pos     <= rem;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_DATA_BITS'({hit_count, res_pos});
      out_user <= {res_evicted, res_hit};
    end
  end

endmodule

// ===== rtl/facr_checker.sv =====
// Port checker for the cache tag store, bound to the top level.
`timescale 1ns / 1ps
`include "fully_associative_cache_random_replace_defines.svh"
module facr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [facr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input logic [facr_pkg::OUT_USER_BITS-1:0]  m_axis_tuser
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Hold a stalled result.
  `FACR_CHECK(a_out_hold, out_stall |=> (m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata})))
  // A result is a hit or an eviction, never both.
  `FACR_CHECK(a_hit_xor_evict, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
  // Drop ready after an address transfer: one lookup at a time.
  `FACR_CHECK(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // Leave reset idle with no result pending.
  `FACR_CHECK_ALWAYS(a_reset_idle, rst |=> (s_axis_tready && !m_axis_tvalid))

endmodule

bind fully_associative_cache_random_replace facr_checker u_facr_checker (.*);

// ===== tb/sv/fully_associative_cache_random_replace_test.sv =====
// Testbench: directed and random lookups against the fully associative cache tag store.
`timescale 1ns / 1ps
module fully_associative_cache_random_replace_test;
  import facr_pkg::*;

  localparam int     CLK_HALF_NS        = 5;
  localparam int     RESET_CYCLES       = 9;
  // One long receiver hold-off, started by the receiver itself after this many results.
  localparam int     HOLD_AFTER_RESULTS = 300;
  localparam int     LONG_HOLD_CYCLES   = 400;
  // Settle time at the end; the worst-case lookup is a full cache with random replacement.
  localparam int     SETTLE_CYCLES      = 100;
  localparam longint TIMEOUT_NS         = 10_000_000;
  localparam int     PHASES             = 9;

  typedef logic [ADDRESS_BITS-1:0] addr_t;
  typedef logic [TAG_BITS-1:0]     tag_t;

  // What one lookup is expected to report.
  typedef struct {
    bit                     hit;
    bit [LINE_IDX_BITS-1:0] line;
    bit                     evicted;
    bit [WORD_BITS-1:0]     total;
  } lookup_t;

  // Shadow copy of the tag store: predicts each lookup and checks the results in order.
  class tag_store_scoreboard;
    bit [TAG_BITS-1:0]  line_tag[MAX_LINES];
    bit                 line_valid[MAX_LINES];
    bit [WORD_BITS-1:0] mwc_upper;
    bit [WORD_BITS-1:0] mwc_lower;
    bit [WORD_BITS-1:0] hit_count;
    bit [CFG_BITS-1:0]  lines_in_use;
    lookup_t            expected_lookups[$];
    int                 errors;

    function new();
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      mwc_upper    = RNG_UPPER_RESET;
      mwc_lower    = RNG_LOWER_RESET;
      hit_count    = '0;
      lines_in_use = CFG_BITS'(LINES_RESET);
      errors       = 0;
    endfunction

    function void set_lines(bit [CFG_BITS-1:0] value);
      lines_in_use = value;
    endfunction

    // Zero acts as one line, anything above the array size as the full array.
    function int unsigned active_lines();
      if (lines_in_use == 0) return 1;
      if (lines_in_use > MAX_LINES) return MAX_LINES;
      return lines_in_use;
    endfunction

    // Advance both multiply-with-carry halves and combine them into one word.
    function bit [WORD_BITS-1:0] next_random_word();
      mwc_upper = RNG_UPPER_MUL * {16'h0, mwc_upper[15:0]} + {16'h0, mwc_upper[31:16]};
      mwc_lower = RNG_LOWER_MUL * {16'h0, mwc_lower[15:0]} + {16'h0, mwc_lower[31:16]};
      return (mwc_upper << 16) + mwc_lower;
    endfunction

    function void predict_lookup(addr_t address);
      tag_t        tag;
      int unsigned n;
      int          i;
      int          pos;
      bit          found;
      bit          evicted;
      lookup_t     r;
      tag     = address[ADDRESS_BITS-1:BYTE_SEL_BITS];
      n       = active_lines();
      found   = 1'b0;
      evicted = 1'b0;
      pos     = -1;
      // Every valid line takes part, in use or not; the lowest match wins.
      for (i = 0; i < MAX_LINES; i++) begin
        if (line_valid[i] && line_tag[i] == tag) begin
          found = 1'b1;
          pos   = i;
          break;
        end
      end
      if (found) begin
        if (hit_count != '1) hit_count++;
      end else begin
        for (i = 0; i < int'(n); i++) begin
          if (!line_valid[i]) begin
            pos = i;
            break;
          end
        end
        if (pos < 0) begin
          pos     = int'(next_random_word() % n);
          evicted = 1'b1;
        end
        line_tag[pos]   = tag;
        line_valid[pos] = 1'b1;
      end
      r.hit     = found;
      r.line    = pos[LINE_IDX_BITS-1:0];
      r.evicted = evicted;
      r.total   = hit_count;
      expected_lookups.push_back(r);
    endfunction

    function void check_lookup(logic [OUT_DATA_BITS-1:0] data,
                               logic [OUT_USER_BITS-1:0] user);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        $error("result transfer with no lookup pending");
        errors++;
        return;
      end
      want = expected_lookups.pop_front();
      if (user[0] !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, user[0]);
        errors++;
      end
      if (data[LINE_IDX_BITS-1:0] !== want.line) begin
        $error("line_index: expected %0d, got %0d", want.line, data[LINE_IDX_BITS-1:0]);
        errors++;
      end
      if (user[1] !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, user[1]);
        errors++;
      end
      if (data[LINE_IDX_BITS +: WORD_BITS] !== want.total) begin
        $error("hit_total: expected %0d, got %0d", want.total,
               data[LINE_IDX_BITS +: WORD_BITS]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction
  endclass

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [OUT_USER_BITS-1:0] m_axis_tuser;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [CFG_BITS-1:0]      cfg_data      = '0;

  tag_store_scoreboard book = new();

  // Idle odds in percent per cycle; the main sequence changes them per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int results_seen  = 0;
  int hold_left     = 0;

  fully_associative_cache_random_replace i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF_NS clk = ~clk;

  // Result side: check every transfer against the oldest prediction, then pick
  // the next tready. Once, well into the run, hold tready low for a long
  // stretch so the output register fills and the block stalls its input.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      book.check_lookup(m_axis_tdata, m_axis_tuser);
      results_seen++;
      if (results_seen == HOLD_AFTER_RESULTS) hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one address; keep tvalid high across back-to-back transfers so it is
  // never dropped and raised again in one step.
  task automatic send_address(addr_t address);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'(address);
    do @(posedge clk); while (!s_axis_tready);
    book.predict_lookup(address);
  endtask

  // Drop tvalid and wait until every predicted lookup has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic write_lines(bit [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_lines(value);
  endtask

  // Mostly addresses from a tag pool a bit larger than the lines in use, so
  // hits, fills and replacements all occur; one in eight is a wild address.
  task automatic run_random_lookups(int count, int unsigned active);
    tag_t        base;
    int unsigned pool;
    addr_t       address;
    base = tag_t'($urandom);
    pool = active + active / 4 + 2;
    repeat (count) begin
      if ($urandom_range(7) == 0) begin
        address = addr_t'($urandom);
      end else begin
        address = addr_t'({tag_t'(base + $urandom_range(pool - 1)),
                           BYTE_SEL_BITS'($urandom)});
      end
      send_address(address);
    end
  endtask

  initial begin
    int unsigned phase_lines[PHASES];
    int          phase_items[PHASES];
    phase_lines = '{16, 3, 40, 1, 1023, 0, 7, 512, 200};
    phase_items = '{150, 150, 200, 100, 300, 100, 150, 600, 100};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lines in use at reset value, address extremes and offset-only changes.
    send_address(26'h0000000);
    send_address(26'h3FFFFFF);
    send_address(26'h000001F);   // same line as address zero: hit
    send_address(26'h3FFFFE0);   // same line as all ones: hit
    send_address(26'h2AAAAAA);
    send_address(26'h1555555);
    send_address(26'h0000020);
    wait_for_results();

    // Shrink to one line: out-of-use lines still hit, misses replace line zero.
    write_lines(CFG_BITS'(1));
    send_address(26'h1555555);
    send_address(26'h0000040);
    send_address(26'h0000000);
    wait_for_results();

    // Zero acts as one line.
    write_lines(CFG_BITS'(0));
    send_address(26'h0000060);
    send_address(26'h3FFFFFF);
    wait_for_results();

    // Above the array size acts as the full array: the next miss fills a free line.
    write_lines(CFG_BITS'(1023));
    send_address(26'h0000080);
    wait_for_results();

    // Three lines, all valid: misses pick a random victim among them.
    write_lines(CFG_BITS'(3));
    send_address(26'h00000A0);
    send_address(26'h00000C0);
    send_address(26'h00000A0);
    wait_for_results();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 49;
      end else if (p < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_lines(CFG_BITS'(phase_lines[p]));
      run_random_lookups(phase_items[p], book.active_lines());
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/facr_pkg.sv
rtl/facr_ctrl.sv
rtl/facr_datapath.sv
rtl/fully_associative_cache_random_replace.sv
rtl/facr_checker.sv
tb/sv/fully_associative_cache_random_replace_test.sv
